/* rtl/day_count_to_date_defines.svh */
// Assertion macros shared by the day count to date RTL.
`ifndef DAY_COUNT_TO_DATE_DEFINES_SVH
`define DAY_COUNT_TO_DATE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DCTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dctd_pkg.sv */
// Constants, types and month table for the day count to date converter.
package dctd_pkg;

  localparam int unsigned BASE_YEAR   = 1970;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned DAY_COUNT_W = 16;
  localparam int unsigned OUT_YEAR_W  = 12;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;

  // Highest year reachable from the widest count, plus margin.
  localparam int unsigned YEAR_SPAN = BASE_YEAR + (2 ** COUNT_BITS) / 365 + 2;
  localparam int unsigned YEAR_W    = ($clog2(YEAR_SPAN) > OUT_YEAR_W) ?
                                      $clog2(YEAR_SPAN) : OUT_YEAR_W;

  localparam int unsigned C4_INIT   = BASE_YEAR % 4;
  localparam int unsigned C100_INIT = BASE_YEAR % 100;
  localparam int unsigned C400_INIT = BASE_YEAR % 400;

  localparam int unsigned YEAR_LEN      = 365;
  localparam int unsigned LEAP_YEAR_LEN = 366;
  localparam int unsigned LEAP_FEB_LEN  = 29;

  localparam logic [MONTH_W-1:0] FEB_IDX  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] DEC_IDX  = MONTH_W'(11);

  typedef logic [COUNT_BITS-1:0] rem_t;

  typedef struct packed {
    logic load_in;
    logic step_year;
    logic step_month;
    logic load_out;
  } dctd_cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } dctd_sts_t;

  // Month lengths of a common year, January at index 0.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] idx);
    logic [DAY_W-1:0] len;
    case (idx)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/dctd_ctrl.sv */
// Sequencer for the year and month walks and the output handshake.
`include "day_count_to_date_defines.svh"

module dctd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  dctd_pkg::dctd_sts_t sts_i,
  output dctd_pkg::dctd_cmd_t cmd_o
);
  import dctd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_YEAR  = 3'b010,
    ST_MONTH = 3'b100
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  dctd_cmd_t cmd;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd            = '0;
    cmd.load_in    = (state_q == ST_IDLE) && in_valid_i;
    cmd.step_year  = (state_q == ST_YEAR) && !sts_i.year_fits;
    cmd.step_month = (state_q == ST_MONTH) && !sts_i.month_fits;
    // Hold the finished item until the output register is free.
    cmd.load_out   = (state_q == ST_MONTH) && sts_i.month_fits && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (cmd.load_in) state_d = ST_YEAR;
      ST_YEAR:  if (sts_i.year_fits) state_d = ST_MONTH;
      ST_MONTH: if (cmd.load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `DCTD_ASSERT_NOW(a_load_out_fits, cmd.load_out, sts_i.month_fits, "output loaded early")
  `DCTD_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(out_valid_q && out_stall_i),
                   "stalled result overwritten")
  `DCTD_ASSERT_NEXT(a_year_to_month, (state_q == ST_YEAR) && sts_i.year_fits,
                    state_q == ST_MONTH, "year walk did not hand over")
  `DCTD_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_q, "result not shown")

endmodule

/* rtl/dctd_dp.sv */
// Datapath: remaining count, year with leap counters, month index, output register.
`include "day_count_to_date_defines.svh"

module dctd_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [dctd_pkg::DAY_COUNT_W-1:0]      day_count_i,
  input  dctd_pkg::dctd_cmd_t                   cmd_i,
  output dctd_pkg::dctd_sts_t                   sts_o,
  output logic [dctd_pkg::OUT_YEAR_W-1:0]       out_year_o,
  output logic [dctd_pkg::MONTH_W-1:0]          out_month_o,
  output logic [dctd_pkg::DAY_W-1:0]            out_day_o,
  output logic                                  bad_count_o
);
  import dctd_pkg::*;

  rem_t               rem_q, rem_d;
  logic [YEAR_W-1:0]  year_q, year_d;
  logic [1:0]         c4_q, c4_d;
  logic [6:0]         c100_q, c100_d;
  logic [8:0]         c400_q, c400_d;
  logic [MONTH_W-1:0] mon_q, mon_d;
  logic               bad_q, bad_d;

  logic [OUT_YEAR_W-1:0] oyear_q;
  logic [MONTH_W-1:0]    omonth_q;
  logic [DAY_W-1:0]      oday_q;
  logic                  obad_q;

  logic [COUNT_BITS+DAY_COUNT_W-1:0] count_ext;
  rem_t                              count_in;
  logic                              leap;
  rem_t                              ylen;
  rem_t                              mlen;

  assign count_ext = {{COUNT_BITS{1'b0}}, day_count_i};
  assign count_in  = count_ext[COUNT_BITS-1:0];

  assign leap = ((c4_q == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);
  assign ylen = leap ? COUNT_BITS'(LEAP_YEAR_LEN) : COUNT_BITS'(YEAR_LEN);
  assign mlen = (leap && (mon_q == FEB_IDX)) ? COUNT_BITS'(LEAP_FEB_LEN)
                                             : COUNT_BITS'(month_len(mon_q));

  assign sts_o.year_fits  = (rem_q <= ylen);
  assign sts_o.month_fits = (rem_q <= mlen);

  always_comb begin
    rem_d  = rem_q;
    year_d = year_q;
    c4_d   = c4_q;
    c100_d = c100_q;
    c400_d = c400_q;
    mon_d  = mon_q;
    bad_d  = bad_q;
    if (cmd_i.load_in) begin
      rem_d  = count_in;
      year_d = YEAR_W'(BASE_YEAR);
      c4_d   = 2'(C4_INIT);
      c100_d = 7'(C100_INIT);
      c400_d = 9'(C400_INIT);
      mon_d  = '0;
      bad_d  = (count_in == '0);
    end else if (cmd_i.step_year) begin
      // Drop one whole year and advance the leap counters.
      rem_d  = rem_q - ylen;
      year_d = year_q + YEAR_W'(1);
      c4_d   = c4_q + 2'd1;
      c100_d = (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
      c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
    end else if (cmd_i.step_month) begin
      rem_d = rem_q - mlen;
      mon_d = mon_q + MONTH_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    year_q <= year_d;
    c4_q   <= c4_d;
    c100_q <= c100_d;
    c400_q <= c400_d;
    mon_q  <= mon_d;
    bad_q  <= bad_d;
    if (cmd_i.load_out) begin
      oyear_q  <= bad_q ? '0 : year_q[OUT_YEAR_W-1:0];
      omonth_q <= bad_q ? '0 : mon_q + MONTH_W'(1);
      oday_q   <= bad_q ? '0 : rem_q[DAY_W-1:0];
      obad_q   <= bad_q;
    end
  end

  assign out_year_o  = oyear_q;
  assign out_month_o = omonth_q;
  assign out_day_o   = oday_q;
  assign bad_count_o = obad_q;

  `DCTD_ASSERT_NOW(a_month_in_range, cmd_i.step_month, mon_q < DEC_IDX,
                   "month walk ran past December")
  `DCTD_ASSERT_NEXT(a_step_year_shrinks, cmd_i.step_year, rem_q < $past(rem_q),
                    "year step did not reduce count")

endmodule

/* rtl/day_count_to_date.sv */
// Top level: day count, with 1 January 1970 as day 1, to year, month and day.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, day_count_i        | into block
//  out     | out_valid_o, out_stall_i, out_year_o,      | out of block
//          | out_month_o, out_day_o, bad_count_o        |
//
// One item at a time: an accept step, then the year walk, one subtraction per cycle,
// removing one whole year each time, then the month walk removing one month each time,
// then the load into the output register.
// Reset clears the sequencer and output valid; no clearing pass.
// A stalled result holds in the output register; the next item is taken and walked,
// then waits at the end of its month walk until the register frees up.
module day_count_to_date (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dctd_pkg::DAY_COUNT_W-1:0] day_count_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dctd_pkg::OUT_YEAR_W-1:0]  out_year_o,
  output logic [dctd_pkg::MONTH_W-1:0]     out_month_o,
  output logic [dctd_pkg::DAY_W-1:0]       out_day_o,
  output logic                             bad_count_o
);
  import dctd_pkg::*;

  dctd_cmd_t cmd;
  dctd_sts_t sts;

  dctd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dctd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .day_count_i (day_count_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_year_o  (out_year_o),
    .out_month_o (out_month_o),
    .out_day_o   (out_day_o),
    .bad_count_o (bad_count_o)
  );

endmodule
